### rtl/rc5_block_cipher_top_assert.svh
// Assertion macros for the RC5 block cipher top level.
// Depends on nothing; included by rc5_block_cipher_top.sv.
`ifndef RC5_BLOCK_CIPHER_TOP_ASSERT_SVH
`define RC5_BLOCK_CIPHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define RC5_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define RC5_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RC5_ASSERT(label, clk, rst, prop, msg)
`define RC5_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### rtl/rc5_pkg.sv
// Shared sizes, codes and types for the RC5 block cipher.
// No dependencies; every other file but the assertion header imports it.
`timescale 1ns / 1ps

package rc5_pkg;

  // Cipher sizing
  localparam int ROUNDS      = 15;
  localparam int KEY_BYTES   = 32;
  localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
  localparam int KEY_WORDS   = (KEY_BYTES + 3) / 4;
  localparam int MIX_STEPS   = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);

  localparam int WORD_W   = 32;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = $clog2(TABLE_WORDS);
  localparam int KW_IDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int STEP_W   = $clog2(MIX_STEPS);

  // Configuration port
  localparam int KEY_REGS   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Magic constants and the fixed mixing rotate
  localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;
  localparam logic [4:0]        ROT_MIX = 5'd3;

  typedef enum logic [KIND_W-1:0] {
    REQ_EXPAND  = 2'd0,
    REQ_ENCRYPT = 2'd1,
    REQ_DECRYPT = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_ENC,
    ALU_DEC,
    ALU_MIX_S,
    ALU_MIX_L
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX_S,
    ST_MIX_L,
    ST_CRYPT,
    ST_FINISH
  } state_t;

  // Key store access from the sequencer
  typedef struct packed {
    logic                rk_we;
    logic [IDX_W-1:0]    rk_addr;
    logic                kw_we;
    logic [KW_IDX_W-1:0] kw_addr;
    logic                kw_load;
    logic [WORD_W-1:0]   wdata;
  } ks_req_t;

endpackage

### rtl/rc5_if.sv
// Request and result channel interfaces for the RC5 block cipher.
// Depends on rc5_pkg.
`timescale 1ns / 1ps

interface rc5_req_if;
  import rc5_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] req_type;
  logic [WORD_W-1:0] block_a;
  logic [WORD_W-1:0] block_b;

  modport source (output valid, output req_type, output block_a, output block_b,
                  input ready);
  modport sink   (input valid, input req_type, input block_a, input block_b,
                  output ready);
endinterface

interface rc5_res_if;
  import rc5_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_a;
  logic [WORD_W-1:0] out_b;
  logic [KIND_W-1:0] out_kind;

  modport source (output valid, output out_a, output out_b, output out_kind,
                  input ready);
  modport sink   (input valid, input out_a, input out_b, input out_kind,
                  output ready);
endinterface

### rtl/rc5_alu.sv
// Shared arithmetic unit: add/subtract, xor and barrel rotate for every step.
// Depends on rc5_pkg.
`timescale 1ns / 1ps

module rc5_alu (
  input  rc5_pkg::alu_op_t          op,
  input  logic [rc5_pkg::WORD_W-1:0] x,
  input  logic [rc5_pkg::WORD_W-1:0] y,
  input  logic [rc5_pkg::WORD_W-1:0] k,
  output logic [rc5_pkg::WORD_W-1:0] result
);
  import rc5_pkg::*;

  // Rotate by the low five bits; a zero amount passes the word through
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input logic [4:0] n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} >> n;
    return d[WORD_W-1:0];
  endfunction

  logic [WORD_W-1:0] xy;
  logic [WORD_W-1:0] sum3;

  assign xy   = x + y;
  assign sum3 = k + xy;

  // Select the step
  always_comb begin
    case (op)
      ALU_ADD:   result = x + k;
      ALU_SUB:   result = x - k;
      ALU_ENC:   result = rotl(x ^ y, y[4:0]) + k;
      ALU_DEC:   result = rotr(x - k, y[4:0]) ^ y;
      ALU_MIX_S: result = rotl(sum3, ROT_MIX);
      ALU_MIX_L: result = rotl(sum3, xy[4:0]);
      default:   result = '0;
    endcase
  end

endmodule

### rtl/rc5_keys.sv
// Key storage: key registers, round-key table and key word store.
// Depends on rc5_pkg.
`timescale 1ns / 1ps

module rc5_keys (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rc5_pkg::ks_req_t              ks,
  output logic [rc5_pkg::WORD_W-1:0]     rk_rdata,
  output logic [rc5_pkg::WORD_W-1:0]     kw_rdata
);
  import rc5_pkg::*;

  logic [CFG_DATA_W-1:0] key_regs   [KEY_REGS];
  logic [WORD_W-1:0]     round_keys [TABLE_WORDS];
  logic [WORD_W-1:0]     key_work   [KEY_WORDS];
  logic [WORD_W-1:0]     load_word  [KEY_WORDS];

  // Take configuration writes; drop indexes past the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_REGS; i++) key_regs[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_REGS))) begin
      key_regs[cfg_index[1:0]] <= cfg_data;
    end
  end

  // Gather key bytes into words, little-endian, zero past the key length
  for (genvar w = 0; w < KEY_WORDS; w++) begin : g_word
    for (genvar j = 0; j < 4; j++) begin : g_byte
      localparam int N = 4 * w + j;
      if (N < KEY_BYTES) begin : g_used
        assign load_word[w][8*j +: 8] = key_regs[N >> 3][8*(N & 7) +: 8];
      end else begin : g_pad
        assign load_word[w][8*j +: 8] = 8'h00;
      end
    end
  end

  // Round-key table, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_WORDS; i++) round_keys[i] <= '0;
    end else if (ks.rk_we) begin
      round_keys[ks.rk_addr] <= ks.wdata;
    end
  end

  // Key word store: bulk load at expand start, then one word per mixing step
  always_ff @(posedge clk) begin
    if (ks.kw_load) begin
      for (int i = 0; i < KEY_WORDS; i++) key_work[i] <= load_word[i];
    end else if (ks.kw_we) begin
      key_work[ks.kw_addr] <= ks.wdata;
    end
  end

  assign rk_rdata = round_keys[ks.rk_addr];
  assign kw_rdata = key_work[ks.kw_addr];

endmodule

### rtl/rc5_ctrl.sv
// Sequencer: runs seeding, mixing and cipher half-rounds through the shared ALU.
// Depends on rc5_pkg, rc5_if and rc5_alu.
`timescale 1ns / 1ps

module rc5_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  rc5_req_if.sink                    req,
  input  logic                       res_take,
  output logic                       res_valid,
  output logic [rc5_pkg::WORD_W-1:0] res_a,
  output logic [rc5_pkg::WORD_W-1:0] res_b,
  output logic [rc5_pkg::KIND_W-1:0] res_kind,
  output rc5_pkg::ks_req_t           ks,
  input  logic [rc5_pkg::WORD_W-1:0] rk_rdata,
  input  logic [rc5_pkg::WORD_W-1:0] kw_rdata
);
  import rc5_pkg::*;

  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [KW_IDX_W-1:0] widx, widx_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [WORD_W-1:0]   a, a_next;
  logic [WORD_W-1:0]   b, b_next;
  req_kind_t           kind, kind_next;

  alu_op_t           alu_op;
  logic [WORD_W-1:0] alu_x, alu_y, alu_k, alu_res;
  logic              odd;

  rc5_alu u_alu (
    .op     (alu_op),
    .x      (alu_x),
    .y      (alu_y),
    .k      (alu_k),
    .result (alu_res)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= REQ_EXPAND;
      idx   <= '0;
      widx  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      idx   <= idx_next;
      widx  <= widx_next;
      step  <= step_next;
    end
  end

  // Working words
  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
  end

  assign odd = idx[0];

  // Next state, ALU operands and key store access
  always_comb begin
    state_next = state;
    kind_next  = kind;
    idx_next   = idx;
    widx_next  = widx;
    step_next  = step;
    a_next     = a;
    b_next     = b;
    alu_op     = ALU_ADD;
    alu_x      = a;
    alu_y      = b;
    alu_k      = rk_rdata;
    ks         = '0;
    ks.rk_addr = idx;
    ks.kw_addr = widx;
    ks.wdata   = alu_res;
    req.ready  = 1'b0;
    res_valid  = 1'b0;

    case (state)
      ST_IDLE: begin
        // take no request while reset is held
        req.ready = !rst;
        if (req.valid && req.ready) begin
          case (req_kind_t'(req.req_type))
            REQ_EXPAND: begin
              ks.kw_load = 1'b1;
              kind_next  = REQ_EXPAND;
              idx_next   = '0;
              a_next     = MAGIC_P;
              state_next = ST_SEED;
            end
            REQ_ENCRYPT: begin
              kind_next  = REQ_ENCRYPT;
              idx_next   = '0;
              a_next     = req.block_a;
              b_next     = req.block_b;
              state_next = ST_CRYPT;
            end
            REQ_DECRYPT: begin
              kind_next  = REQ_DECRYPT;
              idx_next   = IDX_W'(TABLE_WORDS - 1);
              a_next     = req.block_a;
              b_next     = req.block_b;
              state_next = ST_CRYPT;
            end
            default: begin
              // drop the unused request code
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_SEED: begin
        // write P + i*Q, advance the running sum by Q
        alu_op     = ALU_ADD;
        alu_k      = MAGIC_Q;
        ks.rk_we   = 1'b1;
        ks.wdata   = a;
        a_next     = alu_res;
        idx_next   = idx + 1'b1;
        if (idx == IDX_W'(TABLE_WORDS - 1)) begin
          idx_next   = '0;
          widx_next  = '0;
          step_next  = '0;
          a_next     = '0;
          b_next     = '0;
          state_next = ST_MIX_S;
        end
      end

      ST_MIX_S: begin
        alu_op     = ALU_MIX_S;
        ks.rk_we   = 1'b1;
        a_next     = alu_res;
        state_next = ST_MIX_L;
      end

      ST_MIX_L: begin
        alu_op    = ALU_MIX_L;
        alu_k     = kw_rdata;
        ks.kw_we  = 1'b1;
        b_next    = alu_res;
        idx_next  = (idx == IDX_W'(TABLE_WORDS - 1)) ? '0 : idx + 1'b1;
        widx_next = (widx == KW_IDX_W'(KEY_WORDS - 1)) ? '0 : widx + 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_W'(MIX_STEPS - 1)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MIX_S;
        end
      end

      ST_CRYPT: begin
        // even table index updates a, odd updates b
        alu_x = odd ? b : a;
        alu_y = odd ? a : b;
        if (kind == REQ_ENCRYPT) begin
          alu_op = (idx < IDX_W'(2)) ? ALU_ADD : ALU_ENC;
        end else begin
          alu_op = (idx < IDX_W'(2)) ? ALU_SUB : ALU_DEC;
        end
        if (odd) begin
          b_next = alu_res;
        end else begin
          a_next = alu_res;
        end
        if (kind == REQ_ENCRYPT) begin
          idx_next = idx + 1'b1;
          if (idx == IDX_W'(TABLE_WORDS - 1)) state_next = ST_FINISH;
        end else begin
          idx_next = idx - 1'b1;
          if (idx == '0) state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // hold the result until the output register takes it
        res_valid = 1'b1;
        if (res_take) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res_a    = (kind == REQ_EXPAND) ? '0 : a;
  assign res_b    = (kind == REQ_EXPAND) ? '0 : b;
  assign res_kind = kind;

endmodule

### rtl/rc5_block_cipher_top.sv
// Encrypt/decrypt: 32 half-round steps through the shared ALU, one per cycle,
// then a hand-off of the result to the output register.
// Expand: 32 table seed writes, then 96 mixing steps, each a MIX_S and a MIX_L state.
// A new request waits until the result enters the output register; res stalls delay it.
// Reset (rst, synchronous, active high) clears key registers and round keys.
// Depends on rc5_pkg, rc5_if, rc5_keys, rc5_ctrl and the assertion header.
`timescale 1ns / 1ps
`include "rc5_block_cipher_top_assert.svh"

module rc5_block_cipher_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_data,
  rc5_req_if.sink                        req,
  rc5_res_if.source                      res
);
  import rc5_pkg::*;

  ks_req_t           ks;
  logic [WORD_W-1:0] rk_rdata, kw_rdata;
  logic              core_valid, take;
  logic [WORD_W-1:0] core_a, core_b;
  logic [KIND_W-1:0] core_kind;
  logic              res_valid_next;

  rc5_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ks        (ks),
    .rk_rdata  (rk_rdata),
    .kw_rdata  (kw_rdata)
  );

  rc5_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_take  (take),
    .res_valid (core_valid),
    .res_a     (core_a),
    .res_b     (core_b),
    .res_kind  (core_kind),
    .ks        (ks),
    .rk_rdata  (rk_rdata),
    .kw_rdata  (kw_rdata)
  );

  // Output register: free when empty or draining this cycle
  assign take = !res.valid || res.ready;

  always_comb begin
    res_valid_next = res.valid;
    if (core_valid && take) begin
      res_valid_next = 1'b1;
    end else if (res.ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && take) begin
      res.out_a    <= core_a;
      res.out_b    <= core_b;
      res.out_kind <= core_kind;
    end
  end

  // Checks
  `RC5_ASSERT(a_busy_after_accept, clk, rst, (req.valid && req.ready && req.req_type != REQ_NONE) |=> !req.ready, "block still ready after accepting a request")
  `RC5_ASSERT(a_expand_zero, clk, rst, (res.valid && res.out_kind == REQ_EXPAND) |-> (res.out_a == '0 && res.out_b == '0), "expand result carries nonzero words")
  `RC5_ASSERT(a_kind_legal, clk, rst, res.valid |-> (res.out_kind != REQ_NONE), "result for unused request code")

endmodule
